// ----- rtl/bounded_change_making_exhaustive_unit_macros.svh -----
// assertion helpers shared by the rtl
`ifndef BOUNDED_CHANGE_MAKING_EXHAUSTIVE_UNIT_MACROS_SVH
`define BOUNDED_CHANGE_MAKING_EXHAUSTIVE_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define BCME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BCME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BCME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BCME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/bcme_pkg.sv -----
package bcme_pkg;

    // field widths
    localparam int SLOT_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int STOCK_W  = 5;
    localparam int DCOUNT_W = 4;
    localparam int TARGET_W = 20;
    localparam int INDEX_W  = 3;
    localparam int STOCK_MAX = 31;
    localparam int VALUE_MAX = 65535;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic sum_step;
        logic search_step;
        logic emit_load;
        logic dig_clr;
        logic dig_inc;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic dig_at_end;
        logic dig_last;
        logic digit_full;
        logic over_stock;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/bounded_change_making_exhaustive_unit.sv -----
// channel | signals                                   | moves
// --------+-------------------------------------------+------------------------------
// in      | in_valid, in_ready, cmd, slot, coin_value, | one load or solve transaction
//         | coin_stock, denom_count, target            |
// out     | out_valid, out_ready, denom_index,         | one count per denomination
//         | used_coins, found, overflow, last          |
//
// a load writes the addressed table slot; a solve of n denominations totals the stock and,
//   unless refused on stock, walks P = prod(stock[j] + 1) odometer selections and
//   C = sum over j of prod(stock[i] + 1), i > j, digit carries, one odometer digit per cycle
// reset clears the denomination table and all control state at once, no clearing pass
// a stalled out_ready holds the result register and stops emission; no new
//   transaction is taken until the last count of a solve is in the result register

module bounded_change_making_exhaustive_unit #(
    parameter int MAX_DENOMS = 8,
    parameter int MAX_COINS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [bcme_pkg::SLOT_W-1:0]       slot,
    input  logic [bcme_pkg::VALUE_W-1:0]      coin_value,
    input  logic [bcme_pkg::STOCK_W-1:0]      coin_stock,
    input  logic [bcme_pkg::DCOUNT_W-1:0]     denom_count,
    input  logic [bcme_pkg::TARGET_W-1:0]     target,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bcme_pkg::INDEX_W-1:0]      denom_index,
    output logic [bcme_pkg::STOCK_W-1:0]      used_coins,
    output logic                              found,
    output logic                              overflow,
    output logic                              last
);

    // command and status between the sequencer and the datapath
    bcme_pkg::ctrl_cmd_t  cmd_bus;
    bcme_pkg::dp_status_t status;

    // sequencer: idle, stock total, exhaustive search, count emission
    bcme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (cmd),
        .status   (status),
        .cmd_bus  (cmd_bus)
    );

    // datapath: table, odometer with running sum and coin count,
    // best-selection store and result register
    bcme_dp #(
        .MAX_DENOMS (MAX_DENOMS),
        .MAX_COINS  (MAX_COINS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_bus     (cmd_bus),
        .status      (status),
        .slot        (slot),
        .coin_value  (coin_value),
        .coin_stock  (coin_stock),
        .denom_count (denom_count),
        .target      (target),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .denom_index (denom_index),
        .used_coins  (used_coins),
        .found       (found),
        .overflow    (overflow),
        .last        (last)
    );

endmodule

// ----- rtl/bcme_ctrl.sv -----
`include "bounded_change_making_exhaustive_unit_macros.svh"

module bcme_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  bcme_pkg::dp_status_t   status,
    output bcme_pkg::ctrl_cmd_t    cmd_bus
);

    bcme_pkg::state_t state_reg;
    bcme_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcme_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcme_pkg::ST_IDLE:
            begin
                if (in_valid && (op == bcme_pkg::CMD_SOLVE))
                begin
                    state_next = bcme_pkg::ST_SUM;
                end
            end
            bcme_pkg::ST_SUM:
            begin
                if (status.dig_at_end)
                begin
                    state_next = status.over_stock ? bcme_pkg::ST_EMIT
                                                   : bcme_pkg::ST_SEARCH;
                end
            end
            bcme_pkg::ST_SEARCH:
            begin
                if (status.dig_at_end)
                begin
                    state_next = bcme_pkg::ST_EMIT;
                end
            end
            bcme_pkg::ST_EMIT:
            begin
                if (status.out_free && status.dig_last)
                begin
                    state_next = bcme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcme_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_bus  = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            bcme_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == bcme_pkg::CMD_LOAD)
                    begin
                        cmd_bus.load = 1'b1;
                    end
                    else
                    begin
                        cmd_bus.start   = 1'b1;
                        cmd_bus.dig_clr = 1'b1;
                    end
                end
            end
            bcme_pkg::ST_SUM:
            begin
                if (status.dig_at_end)
                begin
                    cmd_bus.dig_clr = 1'b1;
                end
                else
                begin
                    cmd_bus.sum_step = 1'b1;
                    cmd_bus.dig_inc  = 1'b1;
                end
            end
            bcme_pkg::ST_SEARCH:
            begin
                cmd_bus.search_step = 1'b1;
                // after an increment the odometer restarts at the lowest digit
                if (status.dig_at_end || !status.digit_full)
                begin
                    cmd_bus.dig_clr = 1'b1;
                end
                else
                begin
                    cmd_bus.dig_inc = 1'b1;
                end
            end
            bcme_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd_bus.emit_load = 1'b1;
                    cmd_bus.dig_inc   = 1'b1;
                end
            end
            default:
            begin
                cmd_bus = '0;
            end
        endcase
    end

    `BCME_ASSERT_NXT(a_emit_ends, clk, rst_n, (state_reg == bcme_pkg::ST_EMIT) && cmd_bus.emit_load && status.dig_last, state_reg == bcme_pkg::ST_IDLE, "last count not followed by idle")
    `BCME_ASSERT_IMP(a_sum_no_search, clk, rst_n, (state_reg == bcme_pkg::ST_SUM) && status.dig_at_end && status.over_stock, state_next == bcme_pkg::ST_EMIT, "overflowing stock entered search")

endmodule

// ----- rtl/bcme_dp.sv -----
`include "bounded_change_making_exhaustive_unit_macros.svh"

module bcme_dp #(
    parameter int MAX_DENOMS = 8,
    parameter int MAX_COINS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bcme_pkg::ctrl_cmd_t               cmd_bus,
    output bcme_pkg::dp_status_t              status,
    input  logic [bcme_pkg::SLOT_W-1:0]       slot,
    input  logic [bcme_pkg::VALUE_W-1:0]      coin_value,
    input  logic [bcme_pkg::STOCK_W-1:0]      coin_stock,
    input  logic [bcme_pkg::DCOUNT_W-1:0]     denom_count,
    input  logic [bcme_pkg::TARGET_W-1:0]     target,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bcme_pkg::INDEX_W-1:0]      denom_index,
    output logic [bcme_pkg::STOCK_W-1:0]      used_coins,
    output logic                              found,
    output logic                              overflow,
    output logic                              last
);

    localparam int IDX_W = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
    localparam int DIG_W = $clog2(MAX_DENOMS + 1);
    localparam int CNT_W = $clog2(MAX_COINS + 1);
    localparam int SUM_W = $clog2(MAX_COINS * bcme_pkg::VALUE_MAX + 1);
    localparam int CMP_W = (SUM_W > bcme_pkg::TARGET_W) ? SUM_W : bcme_pkg::TARGET_W;
    localparam int TOT_W = $clog2(MAX_DENOMS * bcme_pkg::STOCK_MAX + 1);
    localparam int VEC_W = MAX_DENOMS * bcme_pkg::STOCK_W;

    logic [bcme_pkg::VALUE_W-1:0]  value_reg [MAX_DENOMS];
    logic [bcme_pkg::STOCK_W-1:0]  stock_reg [MAX_DENOMS];
    logic [bcme_pkg::STOCK_W-1:0]  cur_reg   [MAX_DENOMS];
    logic [bcme_pkg::STOCK_W-1:0]  best_reg  [MAX_DENOMS];
    logic [SUM_W-1:0]              prod_reg  [MAX_DENOMS];

    logic [DIG_W-1:0]              n_reg;
    logic [DIG_W-1:0]              dig_reg;
    logic [bcme_pkg::TARGET_W-1:0] target_reg;
    logic [TOT_W-1:0]              tot_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              best_cnt_reg;
    logic                          found_reg;
    logic                          cand_reg;

    logic                          out_valid_reg;
    logic [bcme_pkg::INDEX_W-1:0]  denom_index_reg;
    logic [bcme_pkg::STOCK_W-1:0]  used_coins_reg;
    logic                          found_out_reg;
    logic                          overflow_reg;
    logic                          last_reg;

    logic [IDX_W-1:0]              idx;
    logic [DIG_W-1:0]              n_in;
    logic [VEC_W-1:0]              cur_vec;
    logic [VEC_W-1:0]              best_vec;
    logic                          hit;
    logic                          better;
    logic                          at_end;
    logic                          full;
    logic                          over;

    assign idx    = dig_reg[IDX_W-1:0];
    assign at_end = (dig_reg == n_reg);
    assign full   = at_end || !(cur_reg[idx] < stock_reg[idx]);
    assign over   = (32'(tot_reg) > MAX_COINS);

    // zero means one, anything above the table means the whole table
    always_comb
    begin
        if (denom_count == '0)
        begin
            n_in = DIG_W'(1);
        end
        else if (32'(denom_count) > MAX_DENOMS)
        begin
            n_in = DIG_W'(MAX_DENOMS);
        end
        else
        begin
            n_in = DIG_W'(denom_count);
        end
    end

    // highest denomination in the top bits, so a plain compare is the tie-break
    always_comb
    begin
        for (int j = 0; j < MAX_DENOMS; j++)
        begin
            cur_vec[j*bcme_pkg::STOCK_W +: bcme_pkg::STOCK_W]  = cur_reg[j];
            best_vec[j*bcme_pkg::STOCK_W +: bcme_pkg::STOCK_W] = best_reg[j];
        end
    end

    assign hit    = cand_reg && (CMP_W'(sum_reg) == CMP_W'(target_reg));
    assign better = hit && (!found_reg || (cnt_reg < best_cnt_reg)
                    || ((cnt_reg == best_cnt_reg) && (cur_vec < best_vec)));

    // denomination table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_DENOMS; j++)
            begin
                value_reg[j] <= '0;
                stock_reg[j] <= '0;
            end
        end
        else if (cmd_bus.load && (32'(slot) < MAX_DENOMS))
        begin
            value_reg[IDX_W'(slot)] <= coin_value;
            stock_reg[IDX_W'(slot)] <= coin_stock;
        end
    end

    // odometer, running sum and best selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_reg   <= '0;
            found_reg <= 1'b0;
            cand_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_bus.dig_clr)
            begin
                dig_reg <= '0;
            end
            else if (cmd_bus.dig_inc)
            begin
                dig_reg <= dig_reg + DIG_W'(1);
            end

            if (cmd_bus.start)
            begin
                found_reg <= 1'b0;
                cand_reg  <= 1'b0;
            end
            else if (cmd_bus.search_step)
            begin
                if (better)
                begin
                    found_reg <= 1'b1;
                end
                cand_reg <= !full;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.start)
        begin
            n_reg        <= n_in;
            target_reg   <= target;
            tot_reg      <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            best_cnt_reg <= '0;
            for (int j = 0; j < MAX_DENOMS; j++)
            begin
                cur_reg[j]  <= '0;
                best_reg[j] <= '0;
                prod_reg[j] <= '0;
            end
        end
        else
        begin
            if (cmd_bus.sum_step)
            begin
                tot_reg <= tot_reg + TOT_W'(stock_reg[idx]);
            end
            if (cmd_bus.search_step)
            begin
                // judge the selection left by the previous increment
                if (better)
                begin
                    best_cnt_reg <= cnt_reg;
                    for (int j = 0; j < MAX_DENOMS; j++)
                    begin
                        best_reg[j] <= cur_reg[j];
                    end
                end
                if (!at_end)
                begin
                    if (!full)
                    begin
                        cur_reg[idx]  <= cur_reg[idx] + bcme_pkg::STOCK_W'(1);
                        prod_reg[idx] <= prod_reg[idx] + SUM_W'(value_reg[idx]);
                        sum_reg       <= sum_reg + SUM_W'(value_reg[idx]);
                        cnt_reg       <= cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // digit wraps: take its coins back out
                        cur_reg[idx]  <= '0;
                        prod_reg[idx] <= '0;
                        sum_reg       <= sum_reg - prod_reg[idx];
                        cnt_reg       <= cnt_reg - CNT_W'(cur_reg[idx]);
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_bus.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.emit_load)
        begin
            denom_index_reg <= bcme_pkg::INDEX_W'(dig_reg);
            used_coins_reg  <= best_reg[idx];
            found_out_reg   <= found_reg;
            overflow_reg    <= over;
            last_reg        <= status.dig_last;
        end
    end

    assign status.dig_at_end = at_end;
    assign status.dig_last   = (dig_reg == (n_reg - DIG_W'(1)));
    assign status.digit_full = full;
    assign status.over_stock = over;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign denom_index = denom_index_reg;
    assign used_coins  = used_coins_reg;
    assign found       = found_out_reg;
    assign overflow    = overflow_reg;
    assign last        = last_reg;

    `BCME_ASSERT_IMP(a_cand_nonempty, clk, rst_n, cand_reg, cnt_reg != '0, "empty selection marked as candidate")
    `BCME_ASSERT_IMP(a_best_nonempty, clk, rst_n, found_reg, best_cnt_reg != '0, "found with an empty best selection")
    `BCME_ASSERT_IMP(a_cnt_bound, clk, rst_n, cmd_bus.search_step, 32'(cnt_reg) <= MAX_COINS, "coin count beyond stock limit during search")

endmodule
